// ===== hdl/sorted_event_timer_queue_top_defines.svh =====
// assertion macros for the sorted event timer queue checker
`ifndef SORTED_EVENT_TIMER_QUEUE_TOP_DEFINES_SVH
`define SORTED_EVENT_TIMER_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SETQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SETQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/setq_pkg.sv =====
// shared constants, types and helpers of the sorted event timer queue
`timescale 1ns / 1ps
package setq_pkg;

	localparam int SLOTS_DEF    = 128;
	localparam int TAG_BITS_DEF = 16;
	localparam int TIME_W       = 32;
	localparam int WAIT_W       = 31;
	localparam int WRAP_W       = 20;
	localparam int DELAY_W      = 20;
	localparam int CMD_W        = 2;
	localparam int STATUS_W     = 3;
	localparam int GRP_W        = 16;
	localparam logic [WRAP_W-1:0] WRAP_RESET = WRAP_W'(10000);

	// request commands
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_REBASE = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

	// broadcast operations to the cell row
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_SHIFT = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_SUB   = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [WRAP_W-1:0] sub;
	} ctrl_t;

	// signed order of due times
	function automatic logic time_less(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
		time_less = $signed(a) < $signed(b);
	endfunction

endpackage

// ===== hdl/setq_cell.sv =====
// one list position of the sorted event row, with its insert ripple stage
`timescale 1ns / 1ps
module setq_cell #(
	parameter int  TAG_BITS = setq_pkg::TAG_BITS_DEF,
	parameter int  SLOT_W   = 7,
	parameter bit  IS_HEAD  = 1'b0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  setq_pkg::ctrl_t       ctrl,
	input  logic [setq_pkg::TIME_W+TAG_BITS+SLOT_W:0]   nb_ent,
	input  logic [setq_pkg::TIME_W+TAG_BITS+SLOT_W+1:0] carry_in,
	output logic [setq_pkg::TIME_W+TAG_BITS+SLOT_W:0]   ent,
	output logic [setq_pkg::TIME_W+TAG_BITS+SLOT_W+1:0] carry_out
);

	typedef struct packed {
		logic                       v;
		logic [setq_pkg::TIME_W-1:0] tm;
		logic [TAG_BITS-1:0]        tg;
		logic [SLOT_W-1:0]          sl;
	} ent_t;

	typedef struct packed {
		logic                       v;
		logic                       placed;
		logic [setq_pkg::TIME_W-1:0] tm;
		logic [TAG_BITS-1:0]        tg;
		logic [SLOT_W-1:0]          sl;
	} carry_t;

	ent_t   ent_q;
	carry_t carry_q;
	carry_t cin;
	ent_t   nb;
	logic   take;

	assign cin       = carry_t'(carry_in);
	assign nb        = ent_t'(nb_ent);
	assign ent       = ent_q;
	assign carry_out = carry_q;

	// the head goes after an equal time, later positions go before one
	always_comb begin
		if (IS_HEAD) begin
			take = !ent_q.v || setq_pkg::time_less(cin.tm, ent_q.tm);
		end else begin
			take = !ent_q.v || !setq_pkg::time_less(ent_q.tm, cin.tm);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.v   <= 1'b0;
			carry_q.v <= 1'b0;
		end else begin
			case (ctrl.op)
				setq_pkg::OP_CLEAR: begin
					ent_q.v   <= 1'b0;
					carry_q.v <= 1'b0;
				end
				setq_pkg::OP_SHIFT: begin
					ent_q     <= nb;
					carry_q.v <= 1'b0;
				end
				setq_pkg::OP_SUB: begin
					ent_q.tm  <= ent_q.tm - setq_pkg::TIME_W'(ctrl.sub);
					carry_q.v <= 1'b0;
				end
				default: begin
					if (cin.v && (cin.placed || take)) begin
						ent_q          <= '{v: 1'b1, tm: cin.tm, tg: cin.tg, sl: cin.sl};
						carry_q.v      <= ent_q.v;
						carry_q.placed <= 1'b1;
						carry_q.tm     <= ent_q.tm;
						carry_q.tg     <= ent_q.tg;
						carry_q.sl     <= ent_q.sl;
					end else if (cin.v) begin
						carry_q <= cin;
					end else begin
						carry_q.v <= 1'b0;
					end
				end
			endcase
		end
	end

endmodule

// ===== hdl/sorted_event_timer_queue_top.sv =====
// top level of the sorted event timer queue: sequencer, slot allocator and cell row
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------------------
//   request  | in        | in_valid / in_stall  | cmd, delay, tag
//   result   | out       | out_valid / out_stall| status, event_tag, due_time, wait_ticks, slot
//   config   | in        | cfg_wr_en            | cfg_wr_data (wrap period)
//
// pop and clear give their result in the cycle after the request is taken
// insert and rebase find the lowest free slot through the S_GRP, S_PICKG and S_PICKB
// states, then the new entry ripples down the cell row one cell a cycle; the walk
// state holds until its counter reaches SLOTS to cover that ripple, and no new
// request is taken until the walk has ended
// one request at a time: in_stall is high while busy or while a result waits
// reset empties the list; no clearing pass is needed
`timescale 1ns / 1ps
module sorted_event_timer_queue_top #(
	parameter int SLOTS    = setq_pkg::SLOTS_DEF,
	parameter int TAG_BITS = setq_pkg::TAG_BITS_DEF,
	localparam int SLOT_W  = $clog2(SLOTS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [setq_pkg::CMD_W-1:0]    cmd,
	input  logic [setq_pkg::DELAY_W-1:0]  delay,
	input  logic [TAG_BITS-1:0]           tag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [setq_pkg::STATUS_W-1:0] status,
	output logic [TAG_BITS-1:0]           event_tag,
	output logic signed [setq_pkg::TIME_W-1:0] due_time,
	output logic [setq_pkg::WAIT_W-1:0]   wait_ticks,
	output logic [SLOT_W-1:0]             slot,
	input  logic                          cfg_wr_en,
	input  logic [setq_pkg::WRAP_W-1:0]   cfg_wr_data
);

	localparam int TW     = setq_pkg::TIME_W;
	localparam int NCELL  = SLOTS - 1;
	localparam int G      = setq_pkg::GRP_W;
	localparam int NGRP   = (SLOTS + G - 1) / G;
	localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int BSEL_W = $clog2(G);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int ENT_W  = TW + TAG_BITS + SLOT_W + 1;
	localparam int CAR_W  = ENT_W + 1;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_GRP   = 3'd1;
	localparam logic [2:0] S_PICKG = 3'd2;
	localparam logic [2:0] S_PICKB = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;

	typedef struct packed {
		logic          v;
		logic [TW-1:0] tm;
		logic [TAG_BITS-1:0] tg;
		logic [SLOT_W-1:0]   sl;
	} ent_t;

	typedef struct packed {
		logic          v;
		logic          placed;
		logic [TW-1:0] tm;
		logic [TAG_BITS-1:0] tg;
		logic [SLOT_W-1:0]   sl;
	} carry_t;

	logic [2:0]                  state_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [setq_pkg::WRAP_W-1:0] wrap_q;
	logic [TW-1:0]               now_q;
	logic [SLOTS-1:0]            free_q;
	logic [setq_pkg::CMD_W-1:0]  cmd_q;
	logic [TW-1:0]               t_q;
	logic [TAG_BITS-1:0]         tag_q;
	logic [NGRP-1:0]             grp_q;
	logic [GSEL_W-1:0]           gsel_q;
	logic                        gfound_q;
	carry_t                      inj_q;

	logic [NGRP*G-1:0]           free_pad;
	logic [G-1:0]                grp_bits;
	logic [GSEL_W-1:0]           gsel_c;
	logic                        gfound_c;
	logic [BSEL_W-1:0]           bsel_c;
	logic [SLOT_W-1:0]           new_slot;
	logic                        accept;
	setq_pkg::ctrl_t             ctrl;
	ent_t                        head;
	logic signed [TW:0]          diff;
	logic [setq_pkg::WAIT_W-1:0] wait_c;

	logic [ENT_W-1:0] ents  [NCELL+1];
	logic [CAR_W-1:0] carry [NCELL+1];

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || out_valid;
	assign head     = ent_t'(ents[0]);
	assign free_pad = {{(NGRP*G-SLOTS){1'b0}}, free_q};
	assign grp_bits = free_pad[gsel_q*G +: G];
	assign new_slot = SLOT_W'({gsel_q, bsel_c});

	// first group that holds a free slot
	always_comb begin
		gsel_c   = '0;
		gfound_c = 1'b0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_q[g]) begin
				gsel_c   = GSEL_W'(g);
				gfound_c = 1'b1;
			end
		end
	end

	// lowest free slot inside the chosen group
	always_comb begin
		bsel_c = '0;
		for (int b = G - 1; b >= 0; b--) begin
			if (grp_bits[b]) begin
				bsel_c = BSEL_W'(b);
			end
		end
	end

	// wait on pop, floored at zero and saturated
	always_comb begin
		diff = $signed({head.tm[TW-1], head.tm}) - $signed({now_q[TW-1], now_q});
		if (diff[TW]) begin
			wait_c = '0;
		end else if (diff[TW-1]) begin
			wait_c = '1;
		end else begin
			wait_c = diff[setq_pkg::WAIT_W-1:0];
		end
	end

	// broadcast to the cell row on the cycle a request is taken
	always_comb begin
		ctrl.op  = setq_pkg::OP_NONE;
		ctrl.sub = wrap_q;
		if (accept) begin
			case (cmd)
				setq_pkg::CMD_POP:    ctrl.op = head.v ? setq_pkg::OP_SHIFT : setq_pkg::OP_NONE;
				setq_pkg::CMD_CLEAR:  ctrl.op = setq_pkg::OP_CLEAR;
				setq_pkg::CMD_REBASE: ctrl.op = setq_pkg::OP_SUB;
				default:              ctrl.op = setq_pkg::OP_NONE;
			endcase
		end
	end

	// cell row: entry k takes its neighbor's content on pop, the insert ripples down
	assign carry[0]     = inj_q;
	assign ents[NCELL]  = '0;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		setq_cell #(
			.TAG_BITS (TAG_BITS),
			.SLOT_W   (SLOT_W),
			.IS_HEAD  (k == 0)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.nb_ent    (ents[k+1]),
			.carry_in  (carry[k]),
			.ent       (ents[k]),
			.carry_out (carry[k+1])
		);
	end

	// register port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= setq_pkg::WRAP_RESET;
		end else if (cfg_wr_en) begin
			wrap_q <= cfg_wr_data;
		end
	end

	// sequencer, slot allocator and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			now_q     <= '0;
			free_q    <= {{(SLOTS-1){1'b1}}, 1'b0};
			inj_q.v   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= cmd;
						tag_q <= tag;
						case (cmd)
							setq_pkg::CMD_INSERT: begin
								t_q     <= now_q + TW'(delay);
								state_q <= S_GRP;
							end
							setq_pkg::CMD_REBASE: begin
								t_q     <= now_q;
								now_q   <= now_q - TW'(wrap_q);
								state_q <= S_GRP;
							end
							setq_pkg::CMD_POP: begin
								out_valid <= 1'b1;
								if (head.v) begin
									status          <= setq_pkg::ST_POPPED;
									event_tag       <= head.tg;
									due_time        <= head.tm;
									wait_ticks      <= wait_c;
									slot            <= head.sl;
									now_q           <= head.tm;
									free_q[head.sl] <= 1'b1;
								end else begin
									status     <= setq_pkg::ST_EMPTY;
									event_tag  <= '0;
									due_time   <= '0;
									wait_ticks <= '0;
									slot       <= '0;
								end
							end
							default: begin
								out_valid  <= 1'b1;
								free_q     <= {{(SLOTS-1){1'b1}}, 1'b0};
								status     <= setq_pkg::ST_CLEARED;
								event_tag  <= '0;
								due_time   <= '0;
								wait_ticks <= '0;
								slot       <= '0;
							end
						endcase
					end
				end
				S_GRP: begin
					for (int g = 0; g < NGRP; g++) begin
						grp_q[g] <= |free_pad[g*G +: G];
					end
					state_q <= S_PICKG;
				end
				S_PICKG: begin
					gsel_q   <= gsel_c;
					gfound_q <= gfound_c;
					state_q  <= S_PICKB;
				end
				S_PICKB: begin
					out_valid  <= 1'b1;
					event_tag  <= (cmd_q == setq_pkg::CMD_REBASE) ? tag_q : '0;
					wait_ticks <= '0;
					if (!gfound_q) begin
						status   <= setq_pkg::ST_FULL;
						due_time <= '0;
						slot     <= '0;
						state_q  <= S_IDLE;
					end else begin
						status           <= (cmd_q == setq_pkg::CMD_REBASE) ?
							setq_pkg::ST_CLEARED : setq_pkg::ST_INSERTED;
						due_time         <= t_q;
						slot             <= new_slot;
						free_q[new_slot] <= 1'b0;
						inj_q.v          <= 1'b1;
						inj_q.placed     <= 1'b0;
						inj_q.tm         <= t_q;
						inj_q.tg         <= tag_q;
						inj_q.sl         <= new_slot;
						cnt_q            <= '0;
						state_q          <= S_WALK;
					end
				end
				S_WALK: begin
					// injection is a single-cycle pulse; the ripple has passed the last
					// cell well before the count ends
					inj_q.v <= 1'b0;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SLOTS)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/setq_checker.sv =====
// port-level checker of the sorted event timer queue and its bind
`timescale 1ns / 1ps
`include "sorted_event_timer_queue_top_defines.svh"
module setq_checker #(
	parameter int SLOTS    = setq_pkg::SLOTS_DEF,
	parameter int TAG_BITS = setq_pkg::TAG_BITS_DEF,
	localparam int SLOT_W  = $clog2(SLOTS)
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [setq_pkg::CMD_W-1:0]    cmd,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [setq_pkg::STATUS_W-1:0] status,
	input logic [setq_pkg::TIME_W-1:0]   due_time,
	input logic [SLOT_W-1:0]             slot
);

	`SETQ_ASSERT_NOW(a_no_take_while_pending, in_valid && !in_stall, !out_valid, "request taken while a result waits")
	`SETQ_ASSERT_NEXT(a_pop_clear_answer, in_valid && !in_stall && (cmd == setq_pkg::CMD_POP || cmd == setq_pkg::CMD_CLEAR), out_valid, "pop or clear gave no result next cycle")
	`SETQ_ASSERT_NOW(a_pop_not_end_slot, out_valid && status == setq_pkg::ST_POPPED, slot != '0, "pop reported the end slot")
	`SETQ_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(due_time) && $stable(status), "stalled result changed")

endmodule

bind sorted_event_timer_queue_top setq_checker #(
	.SLOTS    (SLOTS),
	.TAG_BITS (TAG_BITS)
) u_setq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.cmd        (cmd),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.due_time   (due_time),
	.slot       (slot)
);
